### src/nssc_pkg.sv
`default_nettype none

package nssc_pkg;

  localparam int NumCounters = 16;
  localparam int NumUsed = 14;
  localparam int CntIdxW = $clog2(NumCounters);
  localparam int CounterWidthDef = 32;
  localparam int ReadW = 32;
  localparam int LenW = 11;
  localparam int DwordW = 10;
  localparam int SnapW = 8;

  typedef enum logic [1:0] {
    CMD_RX   = 2'd0,
    CMD_TX   = 2'd1,
    CMD_SNAP = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RX_NONE    = 2'd0,
    RX_DELIVER = 2'd1,
    RX_DROP    = 2'd2,
    RX_ERROR   = 2'd3
  } outcome_t;

  localparam logic [CntIdxW-1:0] CntRxPkt    = CntIdxW'(0);
  localparam logic [CntIdxW-1:0] CntRxDrop   = CntIdxW'(1);
  localparam logic [CntIdxW-1:0] CntRxErr    = CntIdxW'(2);
  localparam logic [CntIdxW-1:0] CntRxOver   = CntIdxW'(3);
  localparam logic [CntIdxW-1:0] CntRxLen    = CntIdxW'(4);
  localparam logic [CntIdxW-1:0] CntRxFrame  = CntIdxW'(5);
  localparam logic [CntIdxW-1:0] CntRxCrc    = CntIdxW'(6);
  localparam logic [CntIdxW-1:0] CntTxAbort  = CntIdxW'(7);
  localparam logic [CntIdxW-1:0] CntTxCarr   = CntIdxW'(8);
  localparam logic [CntIdxW-1:0] CntTxHbeat  = CntIdxW'(9);
  localparam logic [CntIdxW-1:0] CntColl     = CntIdxW'(10);
  localparam logic [CntIdxW-1:0] CntTxWindow = CntIdxW'(11);
  localparam logic [CntIdxW-1:0] CntRxFifo   = CntIdxW'(12);
  localparam logic [CntIdxW-1:0] CntTxPkt    = CntIdxW'(13);

  localparam logic [15:0] RxNoPktBit = 16'h8000;
  localparam logic [15:0] RxErrBit   = 16'h4000;
  localparam logic [7:0]  TxAbortMsk = 8'h38;
  localparam logic [7:0]  TxResetMsk = 8'h30;
  localparam logic [7:0]  TxEnMsk    = 8'h3C;

  typedef struct packed {
    logic [NumCounters-1:0] inc_one;
    logic [NumCounters-1:0] add_snap;
    logic [SnapW-1:0]       snap;
  } cnt_upd_t;

  typedef struct packed {
    logic            rx_discard;
    logic            tx_restart;
    logic            tx_enable;
    logic            tx_pop;
    outcome_t        rx_outcome;
    logic [LenW-1:0]   packet_length;
    logic [DwordW-1:0] dword_count;
  } res_t;

  function automatic logic [NumCounters-1:0] err_cause_mask(input logic [2:0] code);
    logic [NumCounters-1:0] m;
    m = '0;
    unique case (code)
      3'd0: m[CntRxOver] = 1'b1;
      3'd1, 3'd3: m[CntRxLen] = 1'b1;
      3'd2, 3'd4: m[CntRxFrame] = 1'b1;
      3'd5: m[CntRxCrc] = 1'b1;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [NumCounters-1:0] snap_mask(input logic [CntIdxW-1:0] off);
    logic [NumCounters-1:0] m;
    m = '0;
    unique case (off)
      CntIdxW'(0): m[CntTxCarr] = 1'b1;
      CntIdxW'(1): m[CntTxHbeat] = 1'b1;
      CntIdxW'(3): m[CntColl] = 1'b1;
      CntIdxW'(4): m[CntTxWindow] = 1'b1;
      CntIdxW'(5): m[CntRxFifo] = 1'b1;
      CntIdxW'(6): m[CntTxPkt] = 1'b1;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### src/nssc_decode.sv
`default_nettype none

module nssc_decode (
  input  wire logic [1:0]                     cmd,
  input  wire logic [15:0]                    status_word,
  input  wire logic                           buffer_ok,
  input  wire logic [nssc_pkg::CntIdxW-1:0]   counter_index,
  input  wire logic [nssc_pkg::SnapW-1:0]     snapshot_value,
  output nssc_pkg::res_t                      res,
  output nssc_pkg::cnt_upd_t                  upd
);

  logic [7:0]                  tb;
  logic [nssc_pkg::LenW-1:0]   len;
  logic [nssc_pkg::LenW:0]     len_sum;

  assign tb      = status_word[7:0];
  assign len     = status_word[nssc_pkg::LenW-1:0];
  assign len_sum = {1'b0, len} + (nssc_pkg::LenW+1)'(3);

  always_comb begin
    res = '0;
    upd = '0;
    upd.snap = snapshot_value;
    unique case (nssc_pkg::cmd_t'(cmd))
      nssc_pkg::CMD_RX: begin
        if (((status_word & nssc_pkg::RxNoPktBit) == '0) && (status_word != '0)) begin
          res.rx_discard = 1'b1;
          if ((status_word & nssc_pkg::RxErrBit) != '0) begin
            res.rx_outcome = nssc_pkg::RX_ERROR;
            upd.inc_one = nssc_pkg::err_cause_mask(status_word[13:11]);
            upd.inc_one[nssc_pkg::CntRxErr] = 1'b1;
          end else begin
            res.packet_length = len;
            res.dword_count   = len_sum[nssc_pkg::LenW:2];
            if (buffer_ok) begin
              res.rx_outcome = nssc_pkg::RX_DELIVER;
              upd.inc_one[nssc_pkg::CntRxPkt] = 1'b1;
            end else begin
              res.rx_outcome = nssc_pkg::RX_DROP;
              upd.inc_one[nssc_pkg::CntRxDrop] = 1'b1;
            end
          end
        end
      end
      nssc_pkg::CMD_TX: begin
        if (tb != '0) begin
          upd.inc_one[nssc_pkg::CntTxAbort] = (tb & nssc_pkg::TxAbortMsk) != '0;
          res.tx_restart = (tb & nssc_pkg::TxResetMsk) != '0;
          res.tx_enable  = (tb & nssc_pkg::TxEnMsk) != '0;
          res.tx_pop     = 1'b1;
        end
      end
      nssc_pkg::CMD_SNAP: begin
        upd.add_snap = nssc_pkg::snap_mask(counter_index);
      end
      nssc_pkg::CMD_READ: begin
        res = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/nssc_counters.sv
`default_nettype none

module nssc_counters #(
  parameter int COUNTER_WIDTH = nssc_pkg::CounterWidthDef
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           upd_en,
  input  wire nssc_pkg::cnt_upd_t             upd,
  input  wire logic [nssc_pkg::CntIdxW-1:0]   rd_idx,
  output logic [nssc_pkg::ReadW-1:0]          rd_value
);

  localparam int RdW = (COUNTER_WIDTH < nssc_pkg::ReadW) ? COUNTER_WIDTH : nssc_pkg::ReadW;

  logic [RdW-1:0] rd_view [nssc_pkg::NumCounters];

  for (genvar i = 0; i < nssc_pkg::NumCounters; i++) begin : g_cnt
    if (i < nssc_pkg::NumUsed) begin : g_used
      logic [COUNTER_WIDTH-1:0] cnt_r;
      logic [COUNTER_WIDTH-1:0] cnt_nxt;
      logic [COUNTER_WIDTH-1:0] amount;

      always_comb begin
        amount = '0;
        if (upd.add_snap[i]) begin
          amount = COUNTER_WIDTH'(upd.snap);
        end else if (upd.inc_one[i]) begin
          amount = COUNTER_WIDTH'(1);
        end
        cnt_nxt = cnt_r + amount;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cnt_r <= '0;
        end else if (upd_en && (upd.add_snap[i] || upd.inc_one[i])) begin
          cnt_r <= cnt_nxt;
        end
      end

      assign rd_view[i] = cnt_r[RdW-1:0];
    end else begin : g_unused
      assign rd_view[i] = '0;
    end
  end

  assign rd_value = nssc_pkg::ReadW'(rd_view[rd_idx]);

endmodule

`default_nettype wire

### src/nic_status_statistics_counter_unit.sv
`default_nettype none
// Each accepted item is held in the input registers, decoded, and then registered as a
// result in res_r; out_valid is high for a single cycle with each result.
// Throughput: one item per cycle; the receiver cannot stall, so busy stays low.
// The counter bank updates at the edge that registers each result, so reads see
// all earlier items.
// Reset: synchronous active-low rst_n clears all counters and both valid flags.

module nic_status_statistics_counter_unit #(
  parameter int COUNTER_WIDTH = nssc_pkg::CounterWidthDef
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       in_cmd,
  input  wire logic [15:0]                      in_status_word,
  input  wire logic                             in_buffer_ok,
  input  wire logic [nssc_pkg::CntIdxW-1:0]     in_counter_index,
  input  wire logic [nssc_pkg::SnapW-1:0]       in_snapshot_value,
  output logic                                  out_valid,
  output logic                                  out_rx_discard,
  output logic                                  out_tx_restart,
  output logic                                  out_tx_enable,
  output logic                                  out_tx_pop,
  output logic [1:0]                            out_rx_outcome,
  output logic [nssc_pkg::LenW-1:0]             out_packet_length,
  output logic [nssc_pkg::DwordW-1:0]           out_dword_count,
  output logic [nssc_pkg::ReadW-1:0]            out_read_value
);

  logic                            in_v_r;
  logic [1:0]                      cmd_r;
  logic [15:0]                     word_r;
  logic                            bufok_r;
  logic [nssc_pkg::CntIdxW-1:0]    idx_r;
  logic [nssc_pkg::SnapW-1:0]      snap_r;

  nssc_pkg::res_t                  res;
  nssc_pkg::cnt_upd_t              upd;
  logic [nssc_pkg::ReadW-1:0]      rd_value;

  logic                            out_v_r;
  nssc_pkg::res_t                  res_r;
  logic [nssc_pkg::ReadW-1:0]      rd_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r   <= in_cmd;
      word_r  <= in_status_word;
      bufok_r <= in_buffer_ok;
      idx_r   <= in_counter_index;
      snap_r  <= in_snapshot_value;
    end
  end

  nssc_decode u_decode (
    .cmd            (cmd_r),
    .status_word    (word_r),
    .buffer_ok      (bufok_r),
    .counter_index  (idx_r),
    .snapshot_value (snap_r),
    .res            (res),
    .upd            (upd)
  );

  nssc_counters #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_counters (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd_en   (in_v_r),
    .upd      (upd),
    .rd_idx   (idx_r),
    .rd_value (rd_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_v_r) begin
      res_r <= res;
      rd_r  <= (nssc_pkg::cmd_t'(cmd_r) == nssc_pkg::CMD_READ) ? rd_value : '0;
    end
  end

  assign out_valid         = out_v_r;
  assign out_rx_discard    = res_r.rx_discard;
  assign out_tx_restart    = res_r.tx_restart;
  assign out_tx_enable     = res_r.tx_enable;
  assign out_tx_pop        = res_r.tx_pop;
  assign out_rx_outcome    = res_r.rx_outcome;
  assign out_packet_length = res_r.packet_length;
  assign out_dword_count   = res_r.dword_count;
  assign out_read_value    = rd_r;

`ifndef SYNTHESIS
  a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_v_r))
    else $error("Result strobe without a registered item.");

  a_len_only_good: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rx_outcome != nssc_pkg::RX_DELIVER
     && out_rx_outcome != nssc_pkg::RX_DROP) |-> (out_packet_length == '0))
    else $error("Packet length given for a packet that is not good.");

  a_reset_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tx_restart) |-> (out_tx_enable && out_tx_pop))
    else $error("Transmitter reset without enable and pop.");

  a_discard_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rx_discard) |-> (out_rx_outcome != nssc_pkg::RX_NONE))
    else $error("Receive discard without a packet outcome.");

  a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_value != '0) |-> (!out_rx_discard && !out_tx_pop))
    else $error("Counter value on a result that is not a read.");
`endif

endmodule

`default_nettype wire
